// ----- rtl/dtpe_pkg.sv -----
// Shared types, widths and calendar tables for the periodic event day counter.
package dtpe_pkg;

    // Number of schedule registers
    localparam int NUM_SCHEDULES = 3;
    localparam int SEL_W  = (NUM_SCHEDULES > 1) ? $clog2(NUM_SCHEDULES) : 1;
    localparam int ADDR_W = SEL_W + 2;
    localparam int DATA_W = 32;

    // Output field widths
    localparam int IDX_W = 2;
    localparam int RES_W = 12;

    // Years relative to 1 March 1600, day numbers, interval and remainder widths
    localparam int YR_W   = 10;
    localparam int DN_W   = 18;
    localparam int DIFF_W = DN_W + 1;
    localparam int DVD_W  = 17;
    localparam int INT_W  = 11;
    localparam int CNT_W  = $clog2(DVD_W);

    // Year bases relative to 1600
    localparam int BASE_TODAY = 300;
    localparam int BASE_CENT  = 100;
    localparam int BASE_SCHED = 400;
    localparam int CENT_STEPS = 5;

    // Input transfer
    typedef struct packed {
        logic       century_flag;
        logic [6:0] year_in_century;
        logic [3:0] month_now;
        logic [4:0] day_now;
    } t_in;

    // Result transfer
    typedef struct packed {
        logic [IDX_W-1:0]        schedule_index;
        logic signed [RES_W-1:0] days_until;
        logic                    last_result;
    } t_out;

    // Schedule register layout
    typedef struct packed {
        logic [7:0] weeks;
        logic [6:0] year;
        logic [3:0] month;
        logic [4:0] day;
    } t_sched;

    // Year adjustment caused by month normalisation and the March-based year
    typedef enum logic [1:0] {
        ADJ_NONE,
        ADJ_DEC,
        ADJ_INC
    } t_yadj;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_TODAY,
        S_SREQ,
        S_SWAIT,
        S_DIFF,
        S_DWAIT,
        S_EMIT
    } t_state;

    // Year adjustment for a raw month code
    function automatic t_yadj month_adj(input logic [3:0] month);
        t_yadj adj;
        case (month) inside
            4'd0, 4'd1, 4'd2: adj = ADJ_DEC;
            4'd15:            adj = ADJ_INC;
            default:          adj = ADJ_NONE;
        endcase
        return adj;
    endfunction

    // Days from 1 March to the first of the normalised month
    function automatic logic [8:0] month_doy(input logic [3:0] month);
        logic [8:0] doy;
        case (month)
            4'd0:    doy = 9'd275;
            4'd1:    doy = 9'd306;
            4'd2:    doy = 9'd337;
            4'd3:    doy = 9'd0;
            4'd4:    doy = 9'd31;
            4'd5:    doy = 9'd61;
            4'd6:    doy = 9'd92;
            4'd7:    doy = 9'd122;
            4'd8:    doy = 9'd153;
            4'd9:    doy = 9'd184;
            4'd10:   doy = 9'd214;
            4'd11:   doy = 9'd245;
            4'd12:   doy = 9'd275;
            4'd13:   doy = 9'd306;
            4'd14:   doy = 9'd337;
            default: doy = 9'd0;
        endcase
        return doy;
    endfunction

endpackage

// ----- rtl/dtpe_regs.sv -----
// APB register bank holding the schedule registers.
module dtpe_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dtpe_pkg::ADDR_W-1:0]    paddr,
    input  logic [dtpe_pkg::DATA_W-1:0]    pwdata,
    output logic [dtpe_pkg::DATA_W-1:0]    prdata,
    output logic                           pready,
    output dtpe_pkg::t_sched               o_sched [dtpe_pkg::NUM_SCHEDULES]
);
    import dtpe_pkg::*;

    t_sched             r_sched [NUM_SCHEDULES];
    logic [SEL_W-1:0]   reg_idx;
    logic               idx_ok;
    logic               wr_en;

    // Decode register index from the word address
    assign reg_idx = paddr[ADDR_W-1:2];
    assign idx_ok  = {1'b0, reg_idx} < (SEL_W + 1)'(NUM_SCHEDULES);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    // Write the addressed schedule; drop writes beyond the bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_SCHEDULES; i++) begin
                r_sched[i] <= '0;
            end
        end else if (wr_en && idx_ok) begin
            r_sched[reg_idx] <= pwdata[$bits(t_sched)-1:0];
        end
    end

    // Read back the addressed schedule
    always_comb begin
        if (idx_ok) begin
            prdata = DATA_W'(r_sched[reg_idx]);
        end else begin
            prdata = '0;
        end
    end

    assign o_sched = r_sched;

endmodule

// ----- rtl/dtpe_daynum.sv -----
// Three-stage day number unit: date to days since 1 March 1600.
module dtpe_daynum (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dtpe_pkg::YR_W-1:0]     i_year_base,
    input  logic [3:0]                    i_month,
    input  logic [4:0]                    i_day,
    output logic                          o_valid,
    output logic [dtpe_pkg::DN_W-1:0]     o_daynum
);
    import dtpe_pkg::*;

    logic              r_v1;
    logic              r_v2;
    logic              r_valid;
    logic [YR_W-1:0]   r_year;
    logic [8:0]        r_doy;
    logic [4:0]        r_day;
    logic [DN_W-1:0]   r_year_days;
    logic [YR_W-1:0]   r_small;
    logic [DN_W-1:0]   r_daynum;

    logic [YR_W-1:0]   n_year;
    logic [2:0]        cent_cnt;
    logic              quad_cent;
    logic [YR_W-1:0]   n_small;

    // Apply the month normalisation to the year
    always_comb begin
        unique case (month_adj(i_month))
            ADJ_DEC: n_year = i_year_base - YR_W'(1);
            ADJ_INC: n_year = i_year_base + YR_W'(1);
            ADJ_NONE: n_year = i_year_base;
            default: n_year = i_year_base;
        endcase
    end

    // Count whole centuries and four-century spans by compare
    always_comb begin
        cent_cnt = '0;
        for (int i = 1; i <= CENT_STEPS; i++) begin
            if (r_year >= YR_W'(i * 100)) begin
                cent_cnt = cent_cnt + 3'd1;
            end
        end
        quad_cent = (r_year >= YR_W'(400));
        n_small   = (r_year >> 2) + YR_W'(r_doy) + YR_W'(r_day)
                  + YR_W'(quad_cent) - YR_W'(cent_cnt);
    end

    // Advance the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_v1    <= i_start;
            r_v2    <= r_v1;
            r_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_year      <= n_year;
        r_doy       <= month_doy(i_month);
        r_day       <= i_day;
        r_year_days <= DN_W'(r_year) * DN_W'(365);
        r_small     <= n_small;
        r_daynum    <= r_year_days + DN_W'(r_small);
    end

    assign o_valid  = r_valid;
    assign o_daynum = r_daynum;

endmodule

// ----- rtl/dtpe_rem.sv -----
// Bit-serial restoring remainder unit, one dividend bit per cycle.
module dtpe_rem (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dtpe_pkg::DVD_W-1:0]    i_dividend,
    input  logic [dtpe_pkg::INT_W-1:0]    i_divisor,
    output logic                          o_done,
    output logic [dtpe_pkg::INT_W-1:0]    o_rem
);
    import dtpe_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DVD_W-1:0]  r_dvd;
    logic [INT_W-1:0]  r_rem;

    logic [INT_W:0]    trial;
    logic [INT_W:0]    n_rem_full;

    // Shift in the next dividend bit and subtract when it fits
    always_comb begin
        trial = {r_rem, r_dvd[DVD_W-1]};
        if (trial >= {1'b0, i_divisor}) begin
            n_rem_full = trial - {1'b0, i_divisor};
        end else begin
            n_rem_full = trial;
        end
    end

    // Sequence the iterations
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= n_rem_full[INT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ----- rtl/days_to_periodic_event.sv -----
// Sequence: today's day number first, then for each schedule with a nonzero interval its day
// number, the difference and the 17-step remainder unit before the result; a schedule with
// a zero interval goes straight to its result.
// Throughput: one item at a time, busy is high from acceptance until the last result.
// Each result is shown for one cycle on o_strobe; the receiver cannot stall.
// Reset (synchronous, active low) clears the sequencer and all schedules to zero.
module days_to_periodic_event (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  dtpe_pkg::t_in                 i_item,
    output logic                          o_strobe,
    output dtpe_pkg::t_out                o_result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [dtpe_pkg::ADDR_W-1:0]   paddr,
    input  logic [dtpe_pkg::DATA_W-1:0]   pwdata,
    output logic [dtpe_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import dtpe_pkg::*;

    t_sched                  sched [NUM_SCHEDULES];

    t_state                  r_state;
    t_state                  n_state;
    logic [SEL_W-1:0]        r_idx;
    logic [SEL_W-1:0]        n_idx;
    logic [DN_W-1:0]         r_today;
    logic [DN_W-1:0]         n_today;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [DIFF_W-1:0] n_diff;
    logic [RES_W-1:0]        r_res;
    logic [RES_W-1:0]        n_res;
    t_sched                  r_work [NUM_SCHEDULES];

    logic                    accept;
    logic                    load_work;
    logic                    shift_work;
    logic                    dn_start;
    logic [YR_W-1:0]         dn_base;
    logic [3:0]              dn_month;
    logic [4:0]              dn_day;
    logic                    dn_valid;
    logic [DN_W-1:0]         dn_daynum;
    logic                    rem_start;
    logic                    rem_done;
    logic [INT_W-1:0]        rem;
    logic [INT_W-1:0]        intvl;
    logic [DIFF_W-1:0]       mag_full;
    logic                    last_sched;

    dtpe_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_sched (sched)
    );

    dtpe_daynum u_daynum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (dn_start),
        .i_year_base (dn_base),
        .i_month     (dn_month),
        .i_day       (dn_day),
        .o_valid     (dn_valid),
        .o_daynum    (dn_daynum)
    );

    dtpe_rem u_rem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (rem_start),
        .i_dividend (mag_full[DVD_W-1:0]),
        .i_divisor  (intvl),
        .o_done     (rem_done),
        .o_rem      (rem)
    );

    // Interval of the schedule at the head of the work line
    assign intvl      = INT_W'({r_work[0].weeks, 3'b000}) - INT_W'(r_work[0].weeks);
    assign mag_full   = r_diff[DIFF_W-1] ? DIFF_W'(-r_diff) : DIFF_W'(r_diff);
    assign last_sched = (r_idx == SEL_W'(NUM_SCHEDULES - 1));
    assign accept     = start && !busy;
    assign busy       = (r_state != S_IDLE);

    // Sequencer: next state and unit controls
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_today    = r_today;
        n_diff     = r_diff;
        n_res      = r_res;
        load_work  = 1'b0;
        shift_work = 1'b0;
        dn_start   = 1'b0;
        rem_start  = 1'b0;
        dn_base    = YR_W'(BASE_SCHED) + YR_W'(r_work[0].year);
        dn_month   = r_work[0].month;
        dn_day     = r_work[0].day;
        unique case (r_state)
            S_IDLE: begin
                dn_base  = YR_W'(BASE_TODAY) + YR_W'(i_item.year_in_century)
                         + (i_item.century_flag ? YR_W'(BASE_CENT) : '0);
                dn_month = i_item.month_now;
                dn_day   = i_item.day_now;
                if (accept) begin
                    dn_start  = 1'b1;
                    load_work = 1'b1;
                    n_idx     = '0;
                    n_state   = S_TODAY;
                end
            end
            S_TODAY: begin
                if (dn_valid) begin
                    n_today = dn_daynum;
                    n_state = S_SREQ;
                end
            end
            S_SREQ: begin
                if (r_work[0].weeks == '0) begin
                    n_res   = '1;
                    n_state = S_EMIT;
                end else begin
                    dn_start = 1'b1;
                    n_state  = S_SWAIT;
                end
            end
            S_SWAIT: begin
                if (dn_valid) begin
                    n_diff  = $signed({1'b0, r_today}) - $signed({1'b0, dn_daynum});
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                rem_start = 1'b1;
                n_state   = S_DWAIT;
            end
            S_DWAIT: begin
                if (rem_done) begin
                    if (r_diff[DIFF_W-1] && (rem != '0)) begin
                        n_res = RES_W'(rem);
                    end else begin
                        n_res = RES_W'(intvl - rem);
                    end
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                shift_work = 1'b1;
                if (last_sched) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx   = r_idx + SEL_W'(1);
                    n_state = S_SREQ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    // Hold datapath registers; load the schedules on acceptance and advance per result
    always_ff @(posedge i_clk) begin
        r_today <= n_today;
        r_diff  <= n_diff;
        r_res   <= n_res;
        if (load_work) begin
            r_work <= sched;
        end else if (shift_work) begin
            for (int i = 0; i < NUM_SCHEDULES - 1; i++) begin
                r_work[i] <= r_work[i+1];
            end
        end
    end

    // Drive the result transfer
    assign o_strobe                = (r_state == S_EMIT);
    assign o_result.schedule_index = IDX_W'(r_idx);
    assign o_result.days_until     = $signed(r_res);
    assign o_result.last_result    = last_sched;

    // A result is only shown while an item is in progress
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> busy)
        else $error("result strobe outside an item");

    // The final result ends the item
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.last_result |=> !busy)
        else $error("block still busy after final result");

    // Accepted item makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    // Results never fall below minus one
    a_res_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($signed(o_result.days_until) >= -12'sd1))
        else $error("result out of range");

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for the periodic event day counter: directed and random dates.
module testbench;
    import dtpe_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int TAIL_CYCLES   = 100;
    localparam int RANDOM_SETS   = 7;
    localparam int DATES_PER_SET = 43;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    logic              busy;
    t_in               i_item  = '0;
    logic              o_strobe;
    t_out              o_result;
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [DATA_W-1:0] pwdata  = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    // Dates waiting to be sent, results owed by the block, and our copy of the schedules
    t_in    pending_dates[$];
    t_out   due_results[$];
    t_sched sched_copy[NUM_SCHEDULES] = '{default: '0};

    logic took_date     = 1'b0;
    logic steady        = 1'b0;
    int   hold_off      = 0;
    int   mismatches    = 0;
    int   dates_sent    = 0;
    int   results_seen  = 0;
    int   settings_used = 1;
    int   cycle_count   = 0;

    days_to_periodic_event u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 i_clk = ~i_clk;

    // Abandon the run if it hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still due",
                     cycle_count, due_results.size());
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Gregorian day number with month 0..15 and day 0..31 rolled into the calendar
    function automatic int calendar_day(input int year, input int month, input int day);
        int m0, y, yy, era, yoe, mp;
        m0 = month - 1;
        y  = year;
        if (m0 < 0) begin
            m0 += 12;
            y  -= 1;
        end else if (m0 >= 12) begin
            m0 -= 12;
            y  += 1;
        end
        // count years from March so that the leap day closes the year
        yy  = (m0 < 2) ? y - 1 : y;
        era = yy / 400;
        yoe = yy - era * 400;
        mp  = (m0 >= 2) ? m0 - 2 : m0 + 10;
        return era * 146097 + yoe * 365 + yoe / 4 - yoe / 100 + (153 * mp + 2) / 5 + day - 1;
    endfunction

    // Days until the schedule's next occurrence, seen from the given day number
    function automatic logic signed [RES_W-1:0] days_until_next(input t_sched s, input int today);
        int span, gap, rem;
        if (s.weeks == 8'd0)
            return RES_W'(-1);
        span = int'(s.weeks) * 7;
        gap  = today - calendar_day(2000 + int'(s.year), int'(s.month), int'(s.day));
        rem  = gap % span;
        return (rem >= 0) ? RES_W'(span - rem) : RES_W'(-rem);
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH at cycle %0d: %s", cycle_count, what);
        mismatches++;
    endtask

    // Present queued dates, idling between transfers once the block is free
    always @(negedge i_clk) begin : drive_dates
        t_in next_date;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !took_date) begin
            // hold the date until the block takes it
        end else if (hold_off > 0) begin
            start <= 1'b0;
            if (!busy)
                hold_off--;
        end else if (pending_dates.size() != 0) begin
            next_date = pending_dates.pop_front();
            i_item   <= next_date;
            start    <= 1'b1;
            hold_off  = steady ? 0 : $urandom_range(0, 4);
        end else begin
            start <= 1'b0;
        end
    end

    // Predict on each accepted date and check each result strobe
    always @(posedge i_clk) begin : watch_results
        int   today;
        t_out want;
        took_date <= i_rst_n && start && !busy;
        if (i_rst_n && start && !busy) begin
            dates_sent++;
            today = calendar_day(1900 + 100 * int'(i_item.century_flag)
                                 + int'(i_item.year_in_century),
                                 int'(i_item.month_now), int'(i_item.day_now));
            for (int k = 0; k < NUM_SCHEDULES; k++) begin
                want.schedule_index = IDX_W'(k);
                want.days_until     = days_until_next(sched_copy[k], today);
                want.last_result    = (k == NUM_SCHEDULES - 1);
                due_results.push_back(want);
            end
        end
        if (i_rst_n && o_strobe) begin
            results_seen++;
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing due: index %0d days %0d",
                                          o_result.schedule_index,
                                          $signed(o_result.days_until)));
            end else begin
                want = due_results.pop_front();
                if (o_result.schedule_index !== want.schedule_index)
                    report_mismatch($sformatf("schedule_index %0d, expected %0d",
                                              o_result.schedule_index, want.schedule_index));
                if (o_result.days_until !== want.days_until)
                    report_mismatch($sformatf("days_until %0d, expected %0d (schedule %0d)",
                                              $signed(o_result.days_until),
                                              $signed(want.days_until), want.schedule_index));
                if (o_result.last_result !== want.last_result)
                    report_mismatch($sformatf("last_result %0b, expected %0b (schedule %0d)",
                                              o_result.last_result, want.last_result,
                                              want.schedule_index));
            end
        end
    end

    task automatic add_date(input logic c, input logic [6:0] y, input logic [3:0] m,
                            input logic [4:0] d);
        t_in date;
        date.century_flag    = c;
        date.year_in_century = y;
        date.month_now       = m;
        date.day_now         = d;
        pending_dates.push_back(date);
    endtask

    // Random date, often on or next to a schedule's start date
    task automatic add_random_date();
        t_in            date;
        t_sched         s;
        logic [16:0]    raw;
        raw  = 17'($urandom);
        date = raw;
        if ($urandom_range(0, 3) == 0) begin
            s = sched_copy[$urandom_range(0, NUM_SCHEDULES - 1)];
            date.century_flag    = 1'b1;
            date.year_in_century = s.year;
            date.month_now       = s.month;
            date.day_now         = s.day + 5'($urandom_range(0, 2)) - 5'd1;
        end
        pending_dates.push_back(date);
    endtask

    // Wait until every date is taken and every result has come
    task automatic settle();
        while (pending_dates.size() != 0 || due_results.size() != 0 || start || busy)
            @(posedge i_clk);
    endtask

    // One register transfer: setup phase, then access phase
    task automatic apb_transfer(input logic wr, input int idx, input logic [DATA_W-1:0] data,
                                output logic [DATA_W-1:0] rd);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        rd = prdata;
        if (wr && pready && idx < NUM_SCHEDULES)
            sched_copy[idx] = data[23:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write a schedule and, if it lies within the bank, read it back
    task automatic write_schedule(input int idx, input logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] word;
        apb_transfer(1'b1, idx, value, word);
        if (idx < NUM_SCHEDULES) begin
            apb_transfer(1'b0, idx, $urandom, word);
            if (word[23:0] !== sched_copy[idx])
                report_mismatch($sformatf("schedule %0d reads %06h, expected %06h",
                                          idx, word[23:0], sched_copy[idx]));
        end
    endtask

    function automatic logic [DATA_W-1:0] random_schedule();
        logic [DATA_W-1:0] v;
        v = $urandom;
        case ($urandom_range(0, 5))
            0: v[23:16] = 8'd0;
            1: v[23:16] = 8'd255;
            2: v[23:16] = 8'd1;
            default: ;
        endcase
        return v;
    endfunction

    initial begin : run
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Schedules at reset value: every interval is zero
        add_date(1'b0, 7'd0, 4'd1, 5'd1);
        add_date(1'b1, 7'd127, 4'd15, 5'd31);
        settle();

        // Short and longest intervals, a zero interval with a date, and a write past the end
        write_schedule(0, {8'h5A, t_sched'{8'd1, 7'd0, 4'd1, 5'd1}});
        write_schedule(1, {8'h00, t_sched'{8'd255, 7'd127, 4'd12, 5'd31}});
        write_schedule(2, {8'hA5, t_sched'{8'd0, 7'd50, 4'd6, 5'd15}});
        write_schedule(NUM_SCHEDULES, 32'hFFFF_FFFF);
        settings_used++;
        add_date(1'b1, 7'd0, 4'd1, 5'd1);      // occurrence day itself
        add_date(1'b1, 7'd0, 4'd1, 5'd2);
        add_date(1'b0, 7'd99, 4'd12, 5'd31);   // one day before the start
        add_date(1'b1, 7'd0, 4'd0, 5'd0);      // month and day zero
        add_date(1'b1, 7'd0, 4'd13, 5'd1);     // month past December
        add_date(1'b1, 7'd0, 4'd15, 5'd31);
        add_date(1'b1, 7'd0, 4'd2, 5'd29);     // leap day in a leap century year
        add_date(1'b0, 7'd0, 4'd2, 5'd29);     // runs into March in 1900
        add_date(1'b1, 7'd127, 4'd12, 5'd31);  // long schedule's own day
        add_date(1'b1, 7'd127, 4'd1, 5'd0);
        add_date(1'b0, 7'd0, 4'd0, 5'd0);
        add_date(1'b1, 7'd127, 4'd15, 5'd31);
        add_date(1'b1, 7'd100, 4'd3, 5'd1);    // year beyond 99
        settle();

        // All-ones and all-zero date fields
        write_schedule(0, 32'hFFFF_FFFF);
        write_schedule(1, {8'h00, t_sched'{8'd1, 7'd0, 4'd0, 5'd0}});
        write_schedule(2, {8'h00, t_sched'{8'd1, 7'd127, 4'd15, 5'd31}});
        settings_used++;
        repeat (5) add_random_date();
        settle();

        // Random schedules, some sets sent back to back
        for (int set = 0; set < RANDOM_SETS; set++) begin
            for (int k = 0; k < NUM_SCHEDULES; k++)
                write_schedule(k, random_schedule());
            if ($urandom_range(0, 2) == 0)
                write_schedule(NUM_SCHEDULES, $urandom);
            settings_used++;
            steady = (set % 3 == 1);
            repeat (DATES_PER_SET) add_random_date();
            settle();
        end
        steady = 1'b0;

        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("%0d dates checked against %0d schedule settings, %0d results compared",
                 dates_sent, settings_used, results_seen);
        if (mismatches == 0) begin
            $display("testbench OK");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
